// ===== hw/rtl/chst_pkg.sv =====
// package for the client heartbeat slot table
// item types, result flags of the slot unit and reset constants; no dependencies
package chst_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int ID_W      = 7;
    localparam int CNT_W     = 8;
    localparam int ACT_W     = 7;
    localparam int MASK_W    = 16;
    localparam int BASE_W    = 6;

    localparam logic [BASE_W-1:0] RELOAD_BASE_RST = 6'd10;
    localparam logic [ACT_W-1:0]  ACT_MAX         = 7'd127;
    localparam logic [CNT_W-1:0]  CNT_MAX         = 8'd255;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_TRIGGER = 1'b1;

    typedef struct packed {
        logic            operation;
        logic [ID_W-1:0] client_id;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0]   assigned_id;
        logic              status;
        logic              resurrected;
        logic [MASK_W-1:0] expired_mask;
        logic              count_resynced;
        logic [ACT_W-1:0]  active_clients;
    } t_out_item;

    // outcome of one slot visit
    typedef struct packed {
        logic [CNT_W-1:0] cnt_next;
        logic             cnt_we;
        logic [ACT_W-1:0] active_next;
        logic             found;
        logic             resurrect;
        logic             expired;
        logic             resync;
    } t_slot_res;

endpackage

// ===== hw/rtl/chst_slot_alu.sv =====
// shared slot unit: one counter visit per cycle for allocate or trigger
// depends on chst_pkg
module chst_slot_alu
    import chst_pkg::*;
(
    input  logic              i_op,
    input  logic              i_match,
    input  logic [CNT_W-1:0]  i_cnt,
    input  logic [ACT_W-1:0]  i_active,
    input  logic [BASE_W-1:0] i_base,
    output t_slot_res         o_res
);

    logic [ACT_W-1:0] active_up;
    logic [ACT_W-1:0] active_trig;
    logic [CNT_W:0]   reload_sum;
    logic             cnt_zero;

    assign cnt_zero    = (i_cnt == '0);
    assign active_up   = (i_active == ACT_MAX) ? i_active : i_active + 1'b1;
    assign active_trig = cnt_zero ? active_up : i_active;
    // twice the active count plus the base, saturating
    assign reload_sum  = {1'b0, active_trig, 1'b0} + (CNT_W+1)'(i_base);

    always_comb begin
        o_res             = '0;
        o_res.cnt_next    = i_cnt;
        o_res.active_next = i_active;
        if (i_op == OP_ALLOC) begin
            if (cnt_zero) begin
                o_res.cnt_next    = CNT_W'(1);
                o_res.cnt_we      = 1'b1;
                o_res.active_next = active_up;
                o_res.found       = 1'b1;
            end
        end else if (i_match) begin
            o_res.resurrect   = cnt_zero;
            o_res.active_next = active_trig;
            o_res.cnt_we      = 1'b1;
            o_res.cnt_next    = reload_sum[CNT_W] ? CNT_MAX : reload_sum[CNT_W-1:0];
        end else if (!cnt_zero) begin
            o_res.cnt_next = i_cnt - 1'b1;
            o_res.cnt_we   = 1'b1;
            if (i_cnt == CNT_W'(1)) begin
                o_res.expired = 1'b1;
                if (i_active <= ACT_W'(1)) begin
                    o_res.active_next = ACT_W'(1);
                    o_res.resync      = 1'b1;
                end else begin
                    o_res.active_next = i_active - 1'b1;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/client_heartbeat_slot_table.sv =====
// top level of the client heartbeat slot table: sequencer, counter array, output register
// depends on chst_pkg and chst_slot_alu
//
// usage
//   input channel  : i_in_valid / o_in_stall / i_in_item, an item is taken when valid
//                    is high and stall is low; operation selects allocate or trigger
//   output channel : o_out_valid / i_out_stall / o_out_item, one result item per input
//   config         : i_cfg_we / i_cfg_data write reload_base, only while the block is idle
// timing
//   one slot is visited per cycle through the shared slot unit
//   trigger  : accept, then a scan of every slot from slot 0, then writeback
//   allocate : stops at the first free slot, or after every slot when the table is full
//   one item at a time; o_in_stall is high from accept until the result is registered
// reset
//   synchronous, active low; all counters cleared (all slots free), active count and
//   round-robin pointer zero, reload_base back to 10
// back-pressure
//   the output register holds a finished item while i_out_stall is high; a new item is
//   accepted meanwhile, and its scan waits in writeback until the register frees up
module client_heartbeat_slot_table
    import chst_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_item,
    input  logic              i_cfg_we,
    input  logic [BASE_W-1:0] i_cfg_data
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WB
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_cnt [SLOTS];
    logic [ACT_W-1:0]  r_active;
    logic [IDX_W-1:0]  r_next_slot;     // round-robin start, already wrapped
    logic [BASE_W-1:0] r_reload_base;

    // per-item working registers
    logic              r_op;
    logic [ID_W-1:0]   r_cid;
    logic [IDX_W-1:0]  r_slot;
    logic [IDX_W-1:0]  r_step;
    logic [ID_W-1:0]   r_assigned;
    logic              r_status;
    logic              r_resurrect;
    logic [MASK_W-1:0] r_mask;
    logic              r_resync;

    logic              r_out_valid;
    t_out_item         r_out_item;

    logic              in_take;
    logic              out_free;
    logic              slot_match;
    logic [IDX_W-1:0]  n_slot;
    logic [ID_W-1:0]   slot_id;
    t_slot_res         alu_res;

    assign in_take    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign slot_id    = ID_W'(r_slot) + ID_W'(1);
    assign slot_match = (r_cid == slot_id);
    assign n_slot     = (r_slot == LAST_IDX) ? '0 : r_slot + 1'b1;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    chst_slot_alu u_alu (
        .i_op     (r_op),
        .i_match  (slot_match),
        .i_cnt    (r_cnt[r_slot]),
        .i_active (r_active),
        .i_base   (r_reload_base),
        .o_res    (alu_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_active      <= '0;
            r_next_slot   <= '0;
            r_reload_base <= RELOAD_BASE_RST;
            r_out_valid   <= 1'b0;
            for (int s = 0; s < SLOTS; s++) begin
                r_cnt[s] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_reload_base <= i_cfg_data;
            end
            // in writeback the register is reloaded below
            if (r_out_valid && !i_out_stall && r_state != S_WB) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_op        <= i_in_item.operation;
                        r_cid       <= i_in_item.client_id;
                        // allocate starts after the last grant, trigger walks from slot 0
                        r_slot      <= (i_in_item.operation == OP_ALLOC) ? r_next_slot : '0;
                        r_step      <= '0;
                        r_assigned  <= '0;
                        r_status    <= 1'b0;
                        r_resurrect <= 1'b0;
                        r_mask      <= '0;
                        r_resync    <= 1'b0;
                        r_state     <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (alu_res.cnt_we) begin
                        r_cnt[r_slot] <= alu_res.cnt_next;
                    end
                    r_active <= alu_res.active_next;
                    r_step   <= r_step + 1'b1;
                    r_slot   <= n_slot;
                    if (r_op == OP_ALLOC) begin
                        if (alu_res.found) begin
                            r_assigned  <= slot_id;
                            r_next_slot <= n_slot;
                            r_state     <= S_WB;
                        end else if (r_step == LAST_IDX) begin
                            r_status <= 1'b1;   // table full
                            r_state  <= S_WB;
                        end
                    end else begin
                        if (alu_res.resurrect) begin
                            r_resurrect <= 1'b1;
                        end
                        if (alu_res.expired) begin
                            r_mask <= r_mask | (MASK_W'(1) << r_slot);
                        end
                        if (alu_res.resync) begin
                            r_resync <= 1'b1;
                        end
                        if (r_step == LAST_IDX) begin
                            r_state <= S_WB;
                        end
                    end
                end
                S_WB: begin
                    if (out_free) begin
                        r_out_item.assigned_id    <= r_assigned;
                        r_out_item.status         <= r_status;
                        r_out_item.resurrected    <= r_resurrect;
                        r_out_item.expired_mask   <= r_mask;
                        r_out_item.count_resynced <= r_resync;
                        r_out_item.active_clients <= r_active;
                        r_out_valid               <= 1'b1;
                        r_state                   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // an accepted item always starts a scan
    a_take_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> (r_state == S_SCAN))
        else $error("accepted item did not start a scan");

    // a full table returns no id and an empty expired mask
    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status) |->
            (o_out_item.assigned_id == '0 && o_out_item.expired_mask == '0))
        else $error("failed allocate carries result data");

    // a granted id never comes with trigger flags or the table-full status
    a_grant_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.assigned_id != '0) |->
            (!o_out_item.resurrected && !o_out_item.count_resynced &&
             o_out_item.expired_mask == '0 && !o_out_item.status))
        else $error("granted id mixed with trigger flags");

    // expiry only reported for existing slots
    a_mask_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_item.expired_mask >> SLOTS) == '0))
        else $error("expired mask names a slot beyond the table");

    // a forced count always leaves at least one active client
    a_resync_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.count_resynced) |-> (o_out_item.active_clients != '0))
        else $error("resynced count is zero");
`endif

endmodule

// ===== dv/client_heartbeat_slot_table_checker.sv =====
`timescale 1ns / 1ps
// result checker for the client heartbeat slot table: mirrors the slot counters and compares
// every result item with its prediction; depends on chst_pkg
module client_heartbeat_slot_table_checker
    import chst_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  t_in_item          i_in_item,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  t_out_item         i_out_item,
    input  logic              i_cfg_we,
    input  logic [BASE_W-1:0] i_cfg_data,
    output int                o_fail_count,
    output int                o_pending
);

    logic [CNT_W-1:0]  live_cnt [SLOTS];
    logic [ACT_W-1:0]  act_cnt;
    logic [5:0]        rr_ptr;
    logic [BASE_W-1:0] reload_base;
    t_out_item         awaited_results [$];
    int                fail_count = 0;

    // works out the result of one item and moves the mirrored table on
    task automatic predict_heartbeat(input t_in_item it, output t_out_item res);
        int start;
        int s;
        int k;
        int reload;
        res = '0;
        if (it.operation == OP_ALLOC) begin
            start      = int'(rr_ptr) % SLOTS;
            res.status = 1'b1;
            for (k = 0; k < SLOTS; k++) begin
                s = (start + k) % SLOTS;
                if (res.status && live_cnt[s] == '0) begin
                    live_cnt[s] = CNT_W'(1);
                    if (act_cnt != ACT_MAX) act_cnt = act_cnt + 1'b1;
                    rr_ptr          = 6'(s + 1);
                    res.assigned_id = ID_W'(s + 1);
                    res.status      = 1'b0;
                end
            end
        end else begin
            for (s = 0; s < SLOTS; s++) begin
                if (int'(it.client_id) == s + 1) begin
                    if (live_cnt[s] == '0) begin
                        if (act_cnt != ACT_MAX) act_cnt = act_cnt + 1'b1;
                        res.resurrected = 1'b1;
                    end
                    reload = 2 * int'(act_cnt) + int'(reload_base);
                    if (reload > int'(CNT_MAX)) reload = int'(CNT_MAX);
                    live_cnt[s] = CNT_W'(reload);
                end else if (live_cnt[s] != '0) begin
                    live_cnt[s] = live_cnt[s] - 1'b1;
                    if (live_cnt[s] == '0) begin
                        res.expired_mask[s] = 1'b1;
                        if (act_cnt <= ACT_W'(1)) begin
                            act_cnt            = ACT_W'(1);
                            res.count_resynced = 1'b1;
                        end else begin
                            act_cnt = act_cnt - 1'b1;
                        end
                    end
                end
            end
        end
        res.active_clients = act_cnt;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item predicted;
        t_out_item oldest;
        if (!i_rst_n) begin
            foreach (live_cnt[s]) live_cnt[s] = '0;
            act_cnt     = '0;
            rr_ptr      = '0;
            reload_base = RELOAD_BASE_RST;
            awaited_results.delete();
        end else begin
            if (i_cfg_we) reload_base = i_cfg_data;
            if (i_in_valid && !i_in_stall) begin
                predict_heartbeat(i_in_item, predicted);
                awaited_results.push_back(predicted);
            end
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    $error("result item with nothing awaited: %h", i_out_item);
                    fail_count++;
                end else begin
                    oldest = awaited_results.pop_front();
                    compare_field("assigned_id", oldest.assigned_id, i_out_item.assigned_id);
                    compare_field("status", oldest.status, i_out_item.status);
                    compare_field("resurrected", oldest.resurrected, i_out_item.resurrected);
                    compare_field("expired_mask", oldest.expired_mask,
                                  i_out_item.expired_mask);
                    compare_field("count_resynced", oldest.count_resynced,
                                  i_out_item.count_resynced);
                    compare_field("active_clients", oldest.active_clients,
                                  i_out_item.active_clients);
                end
            end
        end
        o_pending    <= awaited_results.size();
        o_fail_count <= fail_count;
    end

endmodule

// ===== dv/client_heartbeat_slot_table_tb.sv =====
`timescale 1ns / 1ps
// top of the client heartbeat slot table bench: clock, reset, item stimulus and verdict
// depends on chst_pkg, client_heartbeat_slot_table and client_heartbeat_slot_table_checker
module client_heartbeat_slot_table_tb;
    import chst_pkg::*;

    localparam int SLOTS       = SLOTS_DEF;
    localparam int HOLD_CYCLES = 300;   // length of the long output hold-off
    localparam int PHASE_ITEMS = 80;    // random items per phase

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    t_in_item          in_item   = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    t_out_item         out_item;
    logic              cfg_we    = 1'b0;
    logic [BASE_W-1:0] cfg_data  = '0;

    int   fail_count;
    int   pending;
    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    logic long_hold     = 1'b0;
    int   hold_count    = 0;

    // 20 ns period
    always #10 clk = ~clk;

    client_heartbeat_slot_table #(
        .SLOTS (SLOTS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    client_heartbeat_slot_table_checker #(
        .SLOTS (SLOTS)
    ) result_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // receiver side: random stall, or one long hold-off counted here
    always @(posedge clk) begin
        if (long_hold && hold_count < HOLD_CYCLES) begin
            out_stall  <= 1'b1;
            hold_count <= hold_count + 1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // present one item and hold it until the block takes it, then maybe idle a while
    task automatic offer_item(input t_in_item it);
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // mostly well-formed triggers and allocates, with some out-of-range ids as noise
    function automatic t_in_item random_item();
        t_in_item it;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 40) begin
            it.operation = OP_ALLOC;
            it.client_id = ID_W'($urandom_range(127));   // ignored on allocate
        end else begin
            it.operation = OP_TRIGGER;
            if (pick < 88)
                it.client_id = ID_W'($urandom_range(SLOTS, 1));
            else if (pick < 96)
                it.client_id = $urandom_range(1) ? ID_W'($urandom_range(64, SLOTS + 1)) : '0;
            else
                it.client_id = ID_W'($urandom_range(127, 65));
        end
        return it;
    endfunction

    // sender stops until every awaited result item has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // reload_base is only written while the block is idle
    task automatic write_base(input logic [BASE_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic run_phase(input int idle_send, input int idle_recv,
                             input logic [BASE_W-1:0] base, input bit with_hold);
        drain_results();
        write_base(base);
        send_idle_pct = idle_send;
        stall_pct     = idle_recv;
        if (with_hold) long_hold <= 1'b1;
        for (int k = 0; k < PHASE_ITEMS; k++) begin
            offer_item(random_item());
            // by now the output has been held long enough for the input to back up
            if (with_hold && k == 7) long_hold <= 1'b0;
        end
    endtask

    initial begin : stimulus
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed items with the reset reload_base
        offer_item('{OP_TRIGGER, 7'd0});        // trigger on an empty table
        offer_item('{OP_ALLOC, 7'd127});        // first grant, id field ignored
        offer_item('{OP_TRIGGER, 7'd64});       // lone client expires, count held at one
        offer_item('{OP_TRIGGER, 7'd5});        // free slot brought back to life
        repeat (SLOTS) offer_item('{OP_ALLOC, 7'd0});   // fill up, the last finds no slot
        offer_item('{OP_TRIGGER, 7'd1});        // id 1 reloaded, all but id 5 expire
        offer_item('{OP_TRIGGER, 7'd127});      // id beyond the table only ages slots
        offer_item('{OP_TRIGGER, ID_W'(SLOTS)});// highest valid id

        // random phases over a spread of reload_base settings and idling
        run_phase(0, 0, 6'd63, 1'b0);
        run_phase(55, 0, 6'd0, 1'b0);
        run_phase(0, 55, BASE_W'($urandom_range(63)), 1'b0);
        run_phase(18, 18, BASE_W'($urandom_range(63)), 1'b0);
        run_phase(0, 0, RELOAD_BASE_RST, 1'b1);
        run_phase(0, 0, BASE_W'($urandom_range(63)), 1'b0);

        drain_results();
        repeat (SLOTS + 8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog, well beyond the slowest legal run
    initial begin
        #20000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/chst_pkg.sv
hw/rtl/chst_slot_alu.sv
hw/rtl/client_heartbeat_slot_table.sv
dv/client_heartbeat_slot_table_checker.sv
dv/client_heartbeat_slot_table_tb.sv
